FILE: src/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

FILE: src/dsfd_pkg.sv
`default_nettype none

package dsfd_pkg;

   localparam int NUM_SLOTS     = 2;
   localparam int FRAME_BYTES   = 28;
   localparam int CHANNEL_COUNT = 14;

   localparam int PORT_W = 4;
   localparam int BYTE_W = 8;
   localparam int TICK_W = 32;
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(FRAME_BYTES + 1);

   localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'hFF;
   localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'hFE;

   localparam int POS_SPACE  = 8;
   localparam int POS_ROLL   = 9;
   localparam int POS_CHAN   = 10;
   localparam int POS_BATT   = 24;
   localparam int POS_STAT   = 25;
   localparam int POS_FOOTER = 27;

   // frame bytes 8..25 are the only ones the result needs
   localparam int KEEP_BYTES = POS_STAT - POS_SPACE + 1;
   localparam int KEEP_W     = KEEP_BYTES * BYTE_W;
   localparam int CHAN_HALF_W = (CHANNEL_COUNT / 2) * BYTE_W;

   localparam int REQ_DATA_W = TICK_W + BYTE_W;
   localparam int RSP_DATA_W = TICK_W + KEEP_W;

   // configuration register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_PORT_FIRST  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_PORT_SECOND = 1'b1;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] data;
      logic [TICK_W-1:0] tick;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

FILE: src/dual_sensor_frame_deframer.sv
// Channel   Dir  tdata (low bit first)                          tuser
// req_      in   rx_byte[7:0], tick_now[39:8]                   port_id[3:0]
// rsp_      out  timestamp, sensor_space, rolling_index,        sensor_slot
//                channels_low, channels_high, battery_level,
//                status_flags
// csr_      in   csr_index selects port_id_first / port_id_second
//
// One byte per cycle sustained while the queue has room; rsp_tvalid rises once
// the footer byte has passed the queue register and then the output register.
// Reset is synchronous: both framers return to header wait, queue empties.
// A stalled rsp_ side backs up through the two-entry queue into req_tready;
// bytes keep flowing while the queue has room.
`default_nettype none

module dual_sensor_frame_deframer
   import dsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PORT_W-1:0]     csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // rx_byte, tick_now
   input  wire logic [PORT_W-1:0]     req_tuser,  // port_id
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // timestamp, sensor_space, rolling_index, channels_low, channels_high,
   // battery_level, status_flags
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [SLOT_W-1:0]          rsp_tuser   // sensor_slot
);

   fifo_status_type q_status;
   logic            q_push, q_pop;
   item_type        push_item, pop_item;

   dsfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   dsfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   dsfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: src/dsfd_front.sv
`default_nettype none

module dsfd_front
   import dsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PORT_W-1:0]     csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [PORT_W-1:0]     req_tuser,
   input  wire fifo_status_type       q_status,
   output logic                       q_push,
   output item_type                   q_item
);

   logic [PORT_W-1:0] port_first_ff, port_first_in;
   logic [PORT_W-1:0] port_second_ff, port_second_in;
   logic              hit_first, hit_second;

   always_comb begin
      port_first_in  = port_first_ff;
      port_second_in = port_second_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PORT_FIRST:  port_first_in  = csr_wdata;
            REG_PORT_SECOND: port_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_first_ff  <= '0;
         port_second_ff <= PORT_W'(1);
      end else begin
         port_first_ff  <= port_first_in;
         port_second_ff <= port_second_in;
      end
   end

   // slot 0 wins when both registers hold the same id
   assign hit_first  = (req_tuser == port_first_ff);
   assign hit_second = (req_tuser == port_second_ff);

   // bytes from unknown ports are taken and dropped
   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready && (hit_first || hit_second);

   assign q_item.slot = hit_first ? SLOT_W'(0) : SLOT_W'(1);
   assign q_item.data = req_tdata[BYTE_W-1:0];
   assign q_item.tick = req_tdata[REQ_DATA_W-1:BYTE_W];

endmodule

`default_nettype wire

FILE: src/dsfd_queue.sv
`default_nettype none
`include "assert_macros.svh"

module dsfd_queue
   import dsfd_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire item_type  push_item,
   input  wire logic      pop,
   output item_type       pop_item,
   output fifo_status_type status
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign do_pop       = pop && !status.empty;
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   `ASSERT_CLK(a_count_bound, count_ff != 2'd3, "queue count out of range")
   `ASSERT_CLK(a_ptr_track, (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff),
      "queue pointers disagree with count")

endmodule

`default_nettype wire

FILE: src/dsfd_back.sv
`default_nettype none
`include "assert_macros.svh"

module dsfd_back
   import dsfd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire fifo_status_type       q_status,
   input  wire item_type              q_item,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [SLOT_W-1:0]          rsp_tuser
);

   localparam logic [1:0] PH_WAIT0   = 2'd0;
   localparam logic [1:0] PH_WAIT1   = 2'd1;
   localparam logic [1:0] PH_COLLECT = 2'd2;

   logic [1:0]        phase_ff [NUM_SLOTS];
   logic [1:0]        phase_in [NUM_SLOTS];
   logic [CNT_W-1:0]  count_ff [NUM_SLOTS];
   logic [CNT_W-1:0]  count_in [NUM_SLOTS];
   logic [KEEP_W-1:0] win_ff   [NUM_SLOTS];
   logic [KEEP_W-1:0] win_in   [NUM_SLOTS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KEEP_W-1:0] rsp_win_ff, rsp_win_in;
   logic [TICK_W-1:0] rsp_tick_ff, rsp_tick_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;

   logic [SLOT_W-1:0] s;
   logic [CNT_W-1:0]  cnt;
   logic [KEEP_W-1:0] win_next;
   logic              fire;

   assign q_pop    = !q_status.empty && (!rsp_valid_ff || rsp_tready);
   assign s        = q_item.slot;
   assign cnt      = count_ff[s];
   // window shifts down, so byte 8 ends up in the lowest lane
   assign win_next = {q_item.data, win_ff[s][KEEP_W-1:BYTE_W]};

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         phase_in[i] = phase_ff[i];
         count_in[i] = count_ff[i];
         win_in[i]   = win_ff[i];
      end
      fire = 1'b0;
      if (q_pop) begin
         unique case (phase_ff[s])
            PH_WAIT1: begin
               if (q_item.data == HDR_BYTE) begin
                  count_in[s] = CNT_W'(2);
                  phase_in[s] = PH_COLLECT;
               end else begin
                  count_in[s] = '0;
                  phase_in[s] = PH_WAIT0;
               end
            end
            PH_COLLECT: begin
               if (cnt >= CNT_W'(FRAME_BYTES)) begin
                  count_in[s] = '0;
                  phase_in[s] = PH_WAIT0;
               end else begin
                  if (cnt >= CNT_W'(POS_SPACE) && cnt <= CNT_W'(POS_STAT)) begin
                     win_in[s] = win_next;
                  end
                  if (cnt == CNT_W'(POS_FOOTER)) begin
                     count_in[s] = '0;
                     phase_in[s] = PH_WAIT0;
                     fire        = (q_item.data == FOOTER_BYTE);
                  end else begin
                     count_in[s] = cnt + CNT_W'(1);
                  end
               end
            end
            default: begin
               // first header wait, also the unused phase code
               if (q_item.data == HDR_BYTE) begin
                  count_in[s] = CNT_W'(1);
                  phase_in[s] = PH_WAIT1;
               end else begin
                  phase_in[s] = PH_WAIT0;
               end
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_win_in   = rsp_win_ff;
      rsp_tick_in  = rsp_tick_ff;
      rsp_slot_in  = rsp_slot_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_win_in   = win_ff[s];
         rsp_tick_in  = q_item.tick;
         rsp_slot_in  = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            phase_ff[i] <= PH_WAIT0;
            count_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            phase_ff[i] <= phase_in[i];
            count_ff[i] <= count_in[i];
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         win_ff[i] <= win_in[i];
      end
      rsp_win_ff  <= rsp_win_in;
      rsp_tick_ff <= rsp_tick_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_win_ff, rsp_tick_ff};
   assign rsp_tuser  = rsp_slot_ff;

   `ASSERT_CLK(a_collect_count0,
      (phase_ff[0] == PH_COLLECT) |-> (count_ff[0] >= CNT_W'(2) &&
      count_ff[0] <= CNT_W'(POS_FOOTER)), "slot 0 count out of range in collect")
   `ASSERT_CLK(a_collect_count1,
      (phase_ff[1] == PH_COLLECT) |-> (count_ff[1] >= CNT_W'(2) &&
      count_ff[1] <= CNT_W'(POS_FOOTER)), "slot 1 count out of range in collect")
   `ASSERT_CLK(a_fire_held, (rsp_valid_ff && !rsp_tready) |-> !fire,
      "new frame result while output is stalled")

endmodule

`default_nettype wire
